// ===== rtl/core/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants for the point to segment distance block.
// ----------------------------------------------------------------------------
package psd_pkg;

    // Which part of the segment lies nearest to the query point
    typedef enum logic [1:0] {
        CASE_PERP  = 2'd0,
        CASE_END_A = 2'd1,
        CASE_END_B = 2'd2
    } psd_case_t;

    localparam int CASE_BITS = 2;

    // Queue between the classifier and the arithmetic pipeline
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

endpackage

// ===== rtl/core/psd_front.sv =====
// ----------------------------------------------------------------------------
// psd_front
// Three-stage front end: coordinate differences, squares and cross terms,
// then squared lengths, obtuse-angle tests and cross product magnitude.
// ----------------------------------------------------------------------------
module psd_front #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] end_a_x,
    input  logic signed [COORD_BITS-1:0] end_a_y,
    input  logic signed [COORD_BITS-1:0] end_b_x,
    input  logic signed [COORD_BITS-1:0] end_b_y,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic                         q_ready,
    output logic                         q_push,
    output logic [psd_pkg::CASE_BITS+3*(2*COORD_BITS+1)-1:0] q_data
);

    localparam int DW  = COORD_BITS + 1;
    localparam int SQW = 2 * COORD_BITS;
    localparam int PW  = 2 * COORD_BITS + 2;
    localparam int LW  = 2 * COORD_BITS + 1;
    localparam int MW  = 2 * COORD_BITS + 1;

    logic fen;
    logic f1_valid_reg, f2_valid_reg, f3_valid_reg;

    // stage 1 differences
    logic signed [DW-1:0] ab_x_reg, ab_y_reg, ap_x_reg, ap_y_reg, bp_x_reg, bp_y_reg;
    logic signed [DW-1:0] ab_x_next, ab_y_next, ap_x_next, ap_y_next, bp_x_next, bp_y_next;

    // stage 2 products
    logic signed [PW-1:0] p_abx, p_aby, p_apx, p_apy, p_bpx, p_bpy, p_cr1, p_cr2;
    logic [SQW-1:0] sq_abx_reg, sq_aby_reg, sq_apx_reg, sq_apy_reg, sq_bpx_reg, sq_bpy_reg;
    logic signed [PW-1:0] cr1_reg, cr2_reg;

    // stage 3 classification
    logic [LW-1:0]        lab, lap, lbp;
    logic [LW:0]          sum_a, sum_b;
    logic signed [PW:0]   cr_diff;
    logic [PW:0]          cr_abs;
    psd_pkg::psd_case_t   case_next, case_reg;
    logic [MW-1:0]        mag_reg;
    logic [LW-1:0]        lab_reg, lend_reg, lend_next;

    assign fen      = !(f3_valid_reg && !q_ready);
    assign in_stall = !fen;
    assign q_push   = f3_valid_reg && q_ready;
    assign q_data   = {case_reg, mag_reg, lab_reg, lend_reg};

    // difference vectors
    assign ab_x_next = DW'(end_b_x) - DW'(end_a_x);
    assign ab_y_next = DW'(end_b_y) - DW'(end_a_y);
    assign ap_x_next = DW'(point_x) - DW'(end_a_x);
    assign ap_y_next = DW'(point_y) - DW'(end_a_y);
    assign bp_x_next = DW'(point_x) - DW'(end_b_x);
    assign bp_y_next = DW'(point_y) - DW'(end_b_y);

    // squares and cross terms
    assign p_abx = ab_x_reg * ab_x_reg;
    assign p_aby = ab_y_reg * ab_y_reg;
    assign p_apx = ap_x_reg * ap_x_reg;
    assign p_apy = ap_y_reg * ap_y_reg;
    assign p_bpx = bp_x_reg * bp_x_reg;
    assign p_bpy = bp_y_reg * bp_y_reg;
    assign p_cr1 = ap_y_reg * ab_x_reg;
    assign p_cr2 = ap_x_reg * ab_y_reg;

    // squared lengths, obtuse tests and cross magnitude
    always_comb
    begin
        lab     = {1'b0, sq_abx_reg} + {1'b0, sq_aby_reg};
        lap     = {1'b0, sq_apx_reg} + {1'b0, sq_apy_reg};
        lbp     = {1'b0, sq_bpx_reg} + {1'b0, sq_bpy_reg};
        sum_a   = {1'b0, lab} + {1'b0, lap};
        sum_b   = {1'b0, lab} + {1'b0, lbp};
        cr_diff = cr1_reg - cr2_reg;
        cr_abs  = cr_diff[PW] ? (PW+1)'(-cr_diff) : cr_diff;
        if (sum_a < {1'b0, lbp} || lab == '0)
        begin
            case_next = psd_pkg::CASE_END_A;
            lend_next = lap;
        end
        else if (sum_b < {1'b0, lap})
        begin
            case_next = psd_pkg::CASE_END_B;
            lend_next = lbp;
        end
        else
        begin
            case_next = psd_pkg::CASE_PERP;
            lend_next = lap;
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else if (fen)
        begin
            f1_valid_reg <= in_valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (fen)
        begin
            ab_x_reg   <= ab_x_next;
            ab_y_reg   <= ab_y_next;
            ap_x_reg   <= ap_x_next;
            ap_y_reg   <= ap_y_next;
            bp_x_reg   <= bp_x_next;
            bp_y_reg   <= bp_y_next;
            sq_abx_reg <= p_abx[SQW-1:0];
            sq_aby_reg <= p_aby[SQW-1:0];
            sq_apx_reg <= p_apx[SQW-1:0];
            sq_apy_reg <= p_apy[SQW-1:0];
            sq_bpx_reg <= p_bpx[SQW-1:0];
            sq_bpy_reg <= p_bpy[SQW-1:0];
            cr1_reg    <= p_cr1;
            cr2_reg    <= p_cr2;
            case_reg   <= case_next;
            mag_reg    <= cr_abs[MW-1:0];
            lab_reg    <= lab;
            lend_reg   <= lend_next;
        end
    end

endmodule

// ===== rtl/core/psd_queue.sv =====
// ----------------------------------------------------------------------------
// psd_queue
// Small first-in first-out queue between the front end and the pipeline.
// ----------------------------------------------------------------------------
module psd_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             ready,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0] mem [0:psd_pkg::QUEUE_DEPTH-1];
    logic [psd_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [psd_pkg::QUEUE_CNT_BITS-1:0] cnt_reg;
    logic full;

    assign full     = cnt_reg == psd_pkg::QUEUE_CNT_BITS'(psd_pkg::QUEUE_DEPTH);
    assign empty    = cnt_reg == '0;
    assign ready    = !full || pop;
    assign pop_data = mem[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/core/psd_back.sv =====
// ----------------------------------------------------------------------------
// psd_back
// Arithmetic pipeline: squares the cross magnitude, divides by the squared
// segment length one quotient bit a stage, then takes the square root one
// result bit a stage. All stages advance together unless the output stalls.
// ----------------------------------------------------------------------------
module psd_back #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    output logic q_pop,
    input  logic [psd_pkg::CASE_BITS+3*(2*COORD_BITS+1)-1:0] q_data,
    output logic out_valid,
    input  logic out_stall,
    output logic [COORD_BITS+FRAC_BITS:0] dist_fixed,
    output logic [psd_pkg::CASE_BITS-1:0] nearest_case
);

    localparam int LW  = 2 * COORD_BITS + 1;
    localparam int MW  = 2 * COORD_BITS + 1;
    localparam int KL  = (MW + 1) / 2;
    localparam int KH  = MW - KL;
    localparam int NW  = 2 * MW + 2 * FRAC_BITS;
    localparam int QW  = 2 * COORD_BITS + 1 + 2 * FRAC_BITS;
    localparam int SW  = COORD_BITS + 1 + FRAC_BITS;
    localparam int RDW = 2 * SW;

    logic en;

    // unpacked queue word
    psd_pkg::psd_case_t in_case;
    logic [MW-1:0] in_mag;
    logic [LW-1:0] in_lab, in_lend;

    assign in_case = psd_pkg::psd_case_t'(q_data[psd_pkg::CASE_BITS+MW+2*LW-1 -: 2]);
    assign in_mag  = q_data[MW+2*LW-1 -: MW];
    assign in_lab  = q_data[2*LW-1 -: LW];
    assign in_lend = q_data[LW-1:0];

    assign en    = !(out_valid && out_stall);
    assign q_pop = en && !q_empty;

    // stage 0: partial products of the squared cross magnitude
    logic s0_valid_reg;
    logic [2*KH-1:0] pp_hh_reg;
    logic [MW-1:0]   pp_hl_reg;
    logic [2*KL-1:0] pp_ll_reg;
    psd_pkg::psd_case_t s0_case_reg;
    logic [LW-1:0] s0_lab_reg, s0_lend_reg;
    logic [MW-1:0] pp_hl_next;
    logic [2*KH-1:0] pp_hh_next;
    logic [2*KL-1:0] pp_ll_next;

    assign pp_hh_next = in_mag[MW-1 -: KH] * in_mag[MW-1 -: KH];
    assign pp_hl_next = in_mag[MW-1 -: KH] * in_mag[KL-1:0];
    assign pp_ll_next = in_mag[KL-1:0] * in_mag[KL-1:0];

    // stage 1: scaled dividend, split into start remainder and low bits
    logic [NW-1:0] num_next;
    assign num_next = ({NW{1'b0}} | (NW'(pp_hh_reg) << (2 * KL))
                    | NW'(pp_ll_reg)) + (NW'(pp_hl_reg) << (KL + 1))
                    << (2 * FRAC_BITS);

    logic dv_reg [0:QW];
    logic [LW-1:0] drem_reg [0:QW];
    logic [QW-1:0] dlow_reg [0:QW];
    psd_pkg::psd_case_t dcase_reg [0:QW];
    logic [LW-1:0] dlab_reg [0:QW];
    logic [LW-1:0] dlend_reg [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            dv_reg[0]    <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= q_pop;
            dv_reg[0]    <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_hh_reg    <= pp_hh_next;
            pp_hl_reg    <= pp_hl_next;
            pp_ll_reg    <= pp_ll_next;
            s0_case_reg  <= in_case;
            s0_lab_reg   <= in_lab;
            s0_lend_reg  <= in_lend;
            drem_reg[0]  <= num_next[QW+LW-1:QW];
            dlow_reg[0]  <= num_next[QW-1:0];
            dcase_reg[0] <= s0_case_reg;
            dlab_reg[0]  <= s0_lab_reg;
            dlend_reg[0] <= s0_lend_reg;
        end
    end

    // restoring division, one quotient bit a stage
    genvar gd;
    generate
        for (gd = 0; gd < QW; gd++)
        begin : g_div
            logic [LW:0] trial;
            logic [LW:0] diff;
            logic        take;

            assign trial = {drem_reg[gd], dlow_reg[gd][QW-1]};
            assign diff  = trial - {1'b0, dlab_reg[gd]};
            assign take  = trial >= {1'b0, dlab_reg[gd]};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_reg[gd+1] <= 1'b0;
                else if (en)
                    dv_reg[gd+1] <= dv_reg[gd];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    drem_reg[gd+1]  <= take ? diff[LW-1:0] : trial[LW-1:0];
                    dlow_reg[gd+1]  <= {dlow_reg[gd][QW-2:0], take};
                    dcase_reg[gd+1] <= dcase_reg[gd];
                    dlab_reg[gd+1]  <= dlab_reg[gd];
                    dlend_reg[gd+1] <= dlend_reg[gd];
                end
            end
        end
    endgenerate

    // radicand selection: quotient for the interior case, else endpoint length
    logic sv_reg [0:SW];
    logic [RDW-1:0] srad_reg [0:SW];
    logic [SW+1:0]  srem_reg [0:SW];
    logic [SW-1:0]  sroot_reg [0:SW];
    psd_pkg::psd_case_t scase_reg [0:SW];
    logic [QW-1:0] rad_next;

    assign rad_next = (dcase_reg[QW] == psd_pkg::CASE_PERP) ? dlow_reg[QW]
                    : (QW'(dlend_reg[QW]) << (2 * FRAC_BITS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg[0] <= 1'b0;
        else if (en)
            sv_reg[0] <= dv_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srad_reg[0]  <= RDW'(rad_next);
            srem_reg[0]  <= '0;
            sroot_reg[0] <= '0;
            scase_reg[0] <= dcase_reg[QW];
        end
    end

    // digit-by-digit square root, one result bit a stage
    genvar gs;
    generate
        for (gs = 0; gs < SW; gs++)
        begin : g_sqrt
            logic [SW+3:0] t;
            logic [SW+3:0] trial;
            logic [SW+3:0] diff;
            logic          take;

            assign t     = {srem_reg[gs], srad_reg[gs][RDW-1 -: 2]};
            assign trial = (SW+4)'({sroot_reg[gs], 2'b01});
            assign diff  = t - trial;
            assign take  = t >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sv_reg[gs+1] <= 1'b0;
                else if (en)
                    sv_reg[gs+1] <= sv_reg[gs];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    srem_reg[gs+1]  <= take ? diff[SW+1:0] : t[SW+1:0];
                    sroot_reg[gs+1] <= {sroot_reg[gs][SW-2:0], take};
                    srad_reg[gs+1]  <= {srad_reg[gs][RDW-3:0], 2'b00};
                    scase_reg[gs+1] <= scase_reg[gs];
                end
            end
        end
    endgenerate

    assign out_valid    = sv_reg[SW];
    assign dist_fixed   = sroot_reg[SW];
    assign nearest_case = scase_reg[SW];

endmodule

// ===== rtl/core/point_segment_distance.sv =====
// ----------------------------------------------------------------------------
// point_segment_distance
// Distance from a query point to a line segment, fixed point result.
//
//   channel | direction | handshake          | words
//   in      | input     | in_valid/in_stall  | end_a_x/y, end_b_x/y, point_x/y
//   out     | output    | out_valid/out_stall| dist_fixed, nearest_case
//
// One word enters per cycle while in_stall is low; the arithmetic runs
// through the divider (one quotient bit a stage) and then the square root
// (one result bit a stage).
// Reset clears only the valid flags, queue pointers and count; no clearing pass.
// A stalled output freezes the pipeline; the four-word queue lets the front
// end keep accepting until it fills.
// ----------------------------------------------------------------------------
module point_segment_distance #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] end_a_x,
    input  logic signed [COORD_BITS-1:0] end_a_y,
    input  logic signed [COORD_BITS-1:0] end_b_x,
    input  logic signed [COORD_BITS-1:0] end_b_y,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [COORD_BITS+FRAC_BITS:0] dist_fixed,
    output logic [psd_pkg::CASE_BITS-1:0] nearest_case
);

    localparam int ITEM_W = psd_pkg::CASE_BITS + 3 * (2 * COORD_BITS + 1);

    logic              q_push, q_ready, q_pop, q_empty;
    logic [ITEM_W-1:0] q_wdata, q_rdata;

    // classifier
    psd_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .end_a_x  (end_a_x),
        .end_a_y  (end_a_y),
        .end_b_x  (end_b_x),
        .end_b_y  (end_b_y),
        .point_x  (point_x),
        .point_y  (point_y),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    // decoupling queue
    psd_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .ready     (q_ready),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    // arithmetic pipeline
    psd_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_data       (q_rdata),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dist_fixed   (dist_fixed),
        .nearest_case (nearest_case)
    );

endmodule
